// ===== rtl/sjrb_pkg.sv =====
// Shared types, constants and status codes for the slot jitter ring buffer.
package sjrb_pkg;

  localparam int MAX_SLOTS_DEF  = 16;
  localparam int SLOT_BYTES_DEF = 8;
  localparam int DATA_W         = 64;
  localparam int CNT_W          = 5;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 8;
  localparam int SLOTS_RESET    = 16;

  localparam logic [STATUS_W-1:0] ST_OK          = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_FULL_RETRY  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_EMPTY_RETRY = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_OVERFLOW    = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_UNDERRUN    = STATUS_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKING_MODE = CFG_IDX_W'(1);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] wr_slot;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   rd_slot;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    fill_level;
  } rsp_t;

  typedef struct packed {
    logic                use_data;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    fill_level;
  } ctrl_res_t;

endpackage

// ===== rtl/sjrb_slot_mem.sv =====
// Slot data memory with one write port and one registered read port.
module sjrb_slot_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sjrb_ctrl.sv =====
// Ring indices, fill count, slot valid bits and per-request decisions.
module sjrb_ctrl #(
  parameter int MAX_SLOTS  = 16,
  parameter int RING_DEPTH = 16,
  parameter int IDX_W      = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sjrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sjrb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic                             req_type,
  output logic                             mem_wr_en,
  output logic [IDX_W-1:0]                 mem_wr_addr,
  output logic                             mem_rd_en,
  output logic [IDX_W-1:0]                 mem_rd_addr,
  output sjrb_pkg::ctrl_res_t              res
);
  import sjrb_pkg::*;

  localparam int RST_N = (MAX_SLOTS < SLOTS_RESET) ? MAX_SLOTS : SLOTS_RESET;
  localparam logic [CNT_W-1:0] RST_HALF = CNT_W'(RST_N / 2);

  function automatic logic [CNT_W-1:0] ring_n(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] nn;
    nn = v;
    if (v < CNT_W'(2)) begin
      nn = CNT_W'(2);
    end else if (int'(v) > MAX_SLOTS) begin
      nn = CNT_W'(MAX_SLOTS);
    end
    return nn;
  endfunction

  function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] step,
                                               input logic [CNT_W-1:0] nn);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(idx) + (CNT_W+1)'(step);
    if (sum >= (CNT_W+1)'(nn)) begin
      sum = sum - (CNT_W+1)'(nn);
    end
    return IDX_W'(sum);
  endfunction

  logic [CNT_W-1:0]      slots;
  logic                  blocking;
  logic [IDX_W-1:0]      r_idx;
  logic [IDX_W-1:0]      w_idx;
  logic [CNT_W-1:0]      cnt;
  logic [RING_DEPTH-1:0] valid;

  logic [CNT_W-1:0]      n;
  logic [CNT_W-1:0]      half;
  logic                  full;
  logic                  empty;
  logic [CNT_W-1:0]      cfg_half;

  logic [IDX_W-1:0]      r_idx_next;
  logic [IDX_W-1:0]      w_idx_next;
  logic [CNT_W-1:0]      cnt_next;
  logic [RING_DEPTH-1:0] valid_next;
  logic [STATUS_W-1:0]   status_next;
  logic                  use_data_next;
  logic                  do_write;
  logic                  do_read;

  assign n        = ring_n(slots);
  assign half     = n >> 1;
  assign full     = (cnt == n);
  assign empty    = (cnt == '0);
  assign cfg_half = ring_n(cfg_data[CNT_W-1:0]) >> 1;

  always_comb begin
    r_idx_next    = r_idx;
    w_idx_next    = w_idx;
    cnt_next      = cnt;
    valid_next    = valid;
    status_next   = ST_OK;
    use_data_next = 1'b0;
    do_write      = 1'b0;
    do_read       = 1'b0;
    if (req_type == REQ_WRITE) begin
      if (full) begin
        if (blocking) begin
          status_next = ST_FULL_RETRY;
        end else begin
          r_idx_next  = add_mod(r_idx, half, n);
          cnt_next    = cnt - half;
          status_next = ST_OVERFLOW;
        end
      end else begin
        do_write          = 1'b1;
        valid_next[w_idx] = 1'b1;
        w_idx_next        = add_mod(w_idx, CNT_W'(1), n);
        cnt_next          = cnt + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        if (blocking) begin
          status_next = ST_EMPTY_RETRY;
        end else begin
          w_idx_next  = add_mod(w_idx, half, n);
          cnt_next    = cnt + half;
          valid_next  = '0;
          status_next = ST_UNDERRUN;
        end
      end else begin
        do_read       = 1'b1;
        use_data_next = valid[r_idx];
        r_idx_next    = add_mod(r_idx, CNT_W'(1), n);
        cnt_next      = cnt - CNT_W'(1);
      end
    end
  end

  assign mem_wr_en   = accept && do_write;
  assign mem_wr_addr = w_idx;
  assign mem_rd_en   = accept && do_read;
  assign mem_rd_addr = r_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots    <= CNT_W'(SLOTS_RESET);
      blocking <= 1'b0;
      r_idx    <= '0;
      w_idx    <= IDX_W'(RST_HALF);
      cnt      <= RST_HALF;
      valid    <= '0;
      res      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SLOTS_IN_USE) begin
        slots <= cfg_data[CNT_W-1:0];
        r_idx <= '0;
        w_idx <= IDX_W'(cfg_half);
        cnt   <= cfg_half;
        valid <= '0;
      end else if (cfg_index == CFG_BLOCKING_MODE) begin
        blocking <= cfg_data[0];
      end
    end else if (accept) begin
      r_idx            <= r_idx_next;
      w_idx            <= w_idx_next;
      cnt              <= cnt_next;
      valid            <= valid_next;
      res.use_data     <= use_data_next;
      res.status       <= status_next;
      res.fill_level   <= cnt_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= n)
    else $error("fill count exceeds ring size");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(r_idx) < n) && (CNT_W'(w_idx) < n))
    else $error("ring index outside ring");

  a_ring_dist: assert property (@(posedge clk) disable iff (rst)
    ((((CNT_W+1)'(w_idx) + (CNT_W+1)'(n) - (CNT_W+1)'(r_idx)) >= (CNT_W+1)'(n)) ?
      (((CNT_W+1)'(w_idx) + (CNT_W+1)'(n) - (CNT_W+1)'(r_idx)) - (CNT_W+1)'(n)) :
      ((CNT_W+1)'(w_idx) + (CNT_W+1)'(n) - (CNT_W+1)'(r_idx)))
    == (full ? (CNT_W+1)'(0) : (CNT_W+1)'(cnt)))
    else $error("index distance disagrees with fill count");

  a_retry_hold: assert property (@(posedge clk) disable iff (rst)
    $past(accept) && (res.status == ST_FULL_RETRY || res.status == ST_EMPTY_RETRY)
    |-> (cnt == $past(cnt)) && (r_idx == $past(r_idx)) && (w_idx == $past(w_idx)))
    else $error("refused request changed ring state");
`endif

endmodule

// ===== rtl/slot_jitter_ring_buffer_top.sv =====
// Top level of the slot jitter ring buffer.
//
// Requests arrive on the in channel as beats carrying req_type and wr_slot;
// each accepted beat produces exactly one result beat on the out channel with
// rd_slot, status and fill_level. Configuration beats on the cfg channel write
// slots_in_use (index 0) or blocking_mode (index 1); cfg_ready is always high
// and writes are expected only while no request is outstanding.
// A request is accepted and the slot memory is accessed on that edge; the
// result register and out_valid load on the next edge. One request is in
// flight at a time: in_ready stays low while a request is pending, so even
// with out_ready held high the block takes no new request until the slot
// memory read for the last one is done. When the receiver stalls, the
// result stays in the output register, and in_ready low, until it is taken.
// Reset, and any write of slots_in_use, restarts the ring half full with every
// slot reading as zero; all valid bits clear together.
module slot_jitter_ring_buffer_top #(
  parameter int MAX_SLOTS  = sjrb_pkg::MAX_SLOTS_DEF,
  parameter int SLOT_BYTES = sjrb_pkg::SLOT_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sjrb_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sjrb_pkg::rsp_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sjrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sjrb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sjrb_pkg::*;

  localparam int RING_DEPTH = (MAX_SLOTS < (1 << CNT_W)) ? MAX_SLOTS : (1 << CNT_W);
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int SLOT_W     = 8 * SLOT_BYTES;

  logic              pend;
  logic              accept;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [SLOT_W-1:0] mem_rd_data;
  ctrl_res_t         res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !pend && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  sjrb_ctrl #(
    .MAX_SLOTS  (MAX_SLOTS),
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .req_type    (in_data.req_type),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .res         (res)
  );

  sjrb_slot_mem #(
    .DEPTH (RING_DEPTH),
    .WIDTH (SLOT_W),
    .AW    (IDX_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (in_data.wr_slot[SLOT_W-1:0]),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= accept;
      if (pend) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      out_data.rd_slot    <= res.use_data ? DATA_W'(mem_rd_data) : '0;
      out_data.status     <= res.status;
      out_data.fill_level <= res.fill_level;
    end
  end

`ifndef NO_ASSERTIONS
  a_pend_excl: assert property (@(posedge clk) disable iff (rst) pend |-> !out_valid)
    else $error("request in flight while result register is occupied");

  a_pend_result: assert property (@(posedge clk) disable iff (rst) pend |=> out_valid)
    else $error("request in flight produced no result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed or dropped");
`endif

endmodule

// ===== bench/sjrb_ring_checker.sv =====
// Checker for the slot jitter ring buffer: mirrors the ring and compares every result beat.
`timescale 1ns / 1ps

module sjrb_ring_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  sjrb_pkg::req_t                  in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  sjrb_pkg::rsp_t                  out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sjrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sjrb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fails,
  output int                              pending,
  output int                              results_seen,
  output int                              overflow_seen,
  output int                              underrun_seen,
  output int                              retry_seen
);
  import sjrb_pkg::*;

  localparam logic [DATA_W-1:0] SLOT_MASK = {DATA_W{1'b1}} >> (DATA_W - 8 * SLOT_BYTES_DEF);

  logic [DATA_W-1:0] slot_mem [MAX_SLOTS_DEF];
  logic              slot_live [MAX_SLOTS_DEF];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  int unsigned       fill;
  int unsigned       slots_reg;
  bit                blocking;
  rsp_t              rsp_due [$];

  function automatic int unsigned ring_len();
    if (slots_reg < 2) begin
      return 2;
    end
    if (slots_reg > MAX_SLOTS_DEF) begin
      return MAX_SLOTS_DEF;
    end
    return slots_reg;
  endfunction

  task automatic restart_ring();
    int unsigned n;
    n = ring_len();
    foreach (slot_mem[i]) begin
      slot_mem[i] = '0;
      slot_live[i] = 1'b0;
    end
    rd_ptr = 0;
    wr_ptr = (n / 2) % n;
    fill = n / 2;
  endtask

  function automatic rsp_t apply_request(req_t r);
    int unsigned n;
    int unsigned half;
    rsp_t res;
    n = ring_len();
    half = n / 2;
    res = '0;
    res.status = ST_OK;
    if (r.req_type == REQ_WRITE) begin
      if (fill == n) begin
        if (blocking) begin
          res.status = ST_FULL_RETRY;
        end else begin
          rd_ptr = (rd_ptr + half) % n;
          fill -= half;
          res.status = ST_OVERFLOW;
        end
      end else begin
        slot_mem[wr_ptr] = r.wr_slot & SLOT_MASK;
        slot_live[wr_ptr] = 1'b1;
        wr_ptr = (wr_ptr + 1) % n;
        fill++;
      end
    end else begin
      if (fill == 0) begin
        if (blocking) begin
          res.status = ST_EMPTY_RETRY;
        end else begin
          wr_ptr = (wr_ptr + half) % n;
          fill += half;
          foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
          end
          res.status = ST_UNDERRUN;
        end
      end else begin
        res.rd_slot = slot_live[rd_ptr] ? (slot_mem[rd_ptr] & SLOT_MASK) : '0;
        rd_ptr = (rd_ptr + 1) % n;
        fill--;
      end
    end
    res.fill_level = CNT_W'(fill);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    fails++;
    if (fails <= 100) begin
      $display("ERROR %0t sjrb check: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      slots_reg = SLOTS_RESET;
      blocking = 1'b0;
      restart_ring();
      rsp_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (rsp_due.size() == 0) begin
          report_mismatch("result beat with no request waiting, rd_slot", out_data.rd_slot, '0);
        end else begin
          want = rsp_due.pop_front();
          if (out_data.rd_slot !== want.rd_slot) begin
            report_mismatch("rd_slot", out_data.rd_slot, want.rd_slot);
          end
          if (out_data.status !== want.status) begin
            report_mismatch("status", DATA_W'(out_data.status), DATA_W'(want.status));
          end
          if (out_data.fill_level !== want.fill_level) begin
            report_mismatch("fill_level", DATA_W'(out_data.fill_level), DATA_W'(want.fill_level));
          end
          case (want.status)
            ST_OVERFLOW:                   overflow_seen++;
            ST_UNDERRUN:                   underrun_seen++;
            ST_FULL_RETRY, ST_EMPTY_RETRY: retry_seen++;
            default: ;
          endcase
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SLOTS_IN_USE) begin
          slots_reg = cfg_data[CNT_W-1:0];
          restart_ring();
        end else if (cfg_index == CFG_BLOCKING_MODE) begin
          blocking = cfg_data[0];
        end
      end
      if (in_valid && in_ready) begin
        rsp_due.push_back(apply_request(in_data));
      end
    end
    pending <= rsp_due.size();
  end

endmodule

// ===== bench/tb_slot_jitter_ring_buffer_top.sv =====
// Testbench top for the slot jitter ring buffer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_slot_jitter_ring_buffer_top;
  import sjrb_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 12;
  localparam int PHASE_REQS = 90;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  req_t                  in_data;
  logic                  out_valid;
  logic                  out_ready;
  rsp_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fails;
  int pending;
  int results_seen;
  int overflow_seen;
  int underrun_seen;
  int retry_seen;
  int items_sent;
  int idle_cycles;
  bit tx_gap_en;
  bit rx_stall_en;

  slot_jitter_ring_buffer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sjrb_ring_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .pending       (pending),
    .results_seen  (results_seen),
    .overflow_seen (overflow_seen),
    .underrun_seen (underrun_seen),
    .retry_seen    (retry_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return $urandom_range(0, 2);
    end
    if (roll < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_slot();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int unsigned hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else if (!rx_stall_en || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b0;
        hold = idle_len();
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("slot_jitter_ring_buffer_top: mismatch");
    $finish;
  end

  task automatic send_req(input logic kind, input logic [DATA_W-1:0] payload);
    int unsigned gap;
    gap = tx_gap_en ? idle_len() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: kind, wr_slot: payload};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned slot_pick [PHASES];
    int unsigned read_pct;
    int unsigned mode;
    logic        kind;
    slot_pick = '{2, 16, 0, 31, 3, 1, 17, 5, 16, 2, 9, 4};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_sent = 0;
    tx_gap_en = 1'b1;
    rx_stall_en = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The ring starts half full of cleared slots, so the first read returns zero.
    send_req(REQ_READ, rand_slot());
    send_req(REQ_WRITE, '1);
    send_req(REQ_WRITE, '0);
    send_req(REQ_WRITE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(REQ_WRITE, 64'h5555_5555_5555_5555);

    wait_idle();
    write_reg(CFG_SLOTS_IN_USE, CFG_DATA_W'(2));
    send_req(REQ_WRITE, '1);
    send_req(REQ_WRITE, 64'h0123_4567_89AB_CDEF);
    send_req(REQ_READ, rand_slot());
    send_req(REQ_READ, rand_slot());
    send_req(REQ_READ, rand_slot());
    send_req(REQ_READ, rand_slot());

    wait_idle();
    write_reg(CFG_BLOCKING_MODE, CFG_DATA_W'(1));
    send_req(REQ_READ, rand_slot());
    send_req(REQ_WRITE, 64'hDEAD_BEEF_CAFE_F00D);
    send_req(REQ_WRITE, 64'h8000_0000_0000_0001);
    send_req(REQ_WRITE, rand_slot());
    send_req(REQ_READ, rand_slot());
    send_req(REQ_READ, rand_slot());

    wait_idle();
    write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '1);
    write_reg(CFG_SLOTS_IN_USE, '1);
    send_req(REQ_READ, rand_slot());

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_SLOTS_IN_USE, {3'($urandom), 5'(slot_pick[ph])});
      write_reg(CFG_BLOCKING_MODE, {7'($urandom), 1'(ph % 2)});
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(CFG_BLOCKING_MODE + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
      end
      mode = ph % 4;
      tx_gap_en = (mode == 0) || (mode == 1);
      rx_stall_en = (mode == 0) || (mode == 2);
      read_pct = 30 + 20 * (ph % 3);
      for (int k = 0; k < PHASE_REQS; k++) begin
        if (k == PHASE_REQS / 2 && ph % 3 == 0) begin
          wait_idle();
        end
        kind = ($urandom_range(0, 99) < read_pct) ? REQ_READ : REQ_WRITE;
        send_req(kind, rand_slot());
      end
    end

    wait_idle();
    $display("Sent %0d requests, checked %0d results over %0d ring settings in both modes.",
             items_sent, results_seen, PHASES + 3);
    $display("Overflow resets %0d, underrun resets %0d, retries %0d.",
             overflow_seen, underrun_seen, retry_seen);
    if (fails == 0) begin
      $display("slot_jitter_ring_buffer_top: match");
    end else begin
      $display("slot_jitter_ring_buffer_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sjrb_pkg.sv
rtl/sjrb_slot_mem.sv
rtl/sjrb_ctrl.sv
rtl/slot_jitter_ring_buffer_top.sv
bench/sjrb_ring_checker.sv
bench/tb_slot_jitter_ring_buffer_top.sv
